// File: hw/rtl/base64url_token_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// base64url token decoder assertion macros
// shared check macros, clocked on clk and disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef BASE64URL_TOKEN_DECODER_TOP_DEFINES_SVH
`define BASE64URL_TOKEN_DECODER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define B64T_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define B64T_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define B64T_ASSERT(lbl, prop, msg)
`define B64T_NEVER(lbl, cond, msg)
`endif
`endif

// File: hw/rtl/b64t_pkg.sv
// ----------------------------------------------------------------------------
// b64t_pkg
// shared types, codes and the character lookup of the token decoder
// ----------------------------------------------------------------------------
package b64t_pkg;

  localparam int TOKEN_CHARS_DEF = 43;
  localparam int TOKEN_BYTES_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_LEN  = 2'd1,
    STATUS_BAD_CHAR = 2'd2,
    STATUS_LEFTOVER = 2'd3
  } status_t;

  // one queue entry: the results caused by one character
  typedef struct packed {
    logic       has_byte;
    logic [7:0] byte_val;
    logic [4:0] index;
    logic       has_status;
    status_t    status;
  } rec_t;

  // returns {valid, value}
  function automatic logic [6:0] map_char(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c inside {[8'h41:8'h5A]}) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c inside {[8'h61:8'h7A]}) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2D) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h5F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/base64url_token_decoder_top.sv
// ----------------------------------------------------------------------------
// base64url token decoder
// unpadded base64url characters in, decoded bytes and a token status out
// ----------------------------------------------------------------------------
// path: a result is written into the record queue when its character is accepted,
//   then loaded into the output register, from which it is popped
// rate: one character per cycle while the queue is not full; a final character
//   that also completes a byte gives two results, the data byte and then the status
// the record queue (QUEUE_DEPTH entries) sets how long input runs past a stall
// reset: synchronous rst clears token state, queue pointers and the valid flag of the output register
// ----------------------------------------------------------------------------
module base64url_token_decoder_top #(
  parameter int TOKEN_CHARS = b64t_pkg::TOKEN_CHARS_DEF,
  parameter int TOKEN_BYTES = b64t_pkg::TOKEN_BYTES_DEF,
  parameter int QUEUE_DEPTH = b64t_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // character side
  input  logic [7:0] character,
  input  logic       final_char,
  input  logic       push,
  output logic       full,
  // result side
  output logic       kind,
  output logic [7:0] data_byte,
  output logic [4:0] byte_index,
  output logic [1:0] status,
  output logic       run_end,
  output logic       empty,
  input  logic       pop
);
  import b64t_pkg::*;

  // front -> queue
  rec_t wr_rec;
  logic wr_en;
  logic q_full;
  // queue -> back
  rec_t head;
  logic q_empty;
  logic q_pop;

  // front decodes each character and updates the token counters at accept;
  // it writes one record per character that causes any result
  b64t_front #(
    .TOKEN_CHARS(TOKEN_CHARS),
    .TOKEN_BYTES(TOKEN_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .character (character),
    .final_char(final_char),
    .push      (push),
    .full      (full),
    .q_full    (q_full),
    .rec_valid (wr_en),
    .rec       (wr_rec)
  );

  // records wait here so a stalled consumer does not stall the character side until the queue is full
  b64t_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr_en (wr_en),
    .wr_rec(wr_rec),
    .full  (q_full),
    .rd_en (q_pop),
    .rd_rec(head),
    .empty (q_empty)
  );

  // back turns a record into a data byte item, a status item, or both in order
  b64t_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .kind      (kind),
    .data_byte (data_byte),
    .byte_index(byte_index),
    .status    (status),
    .run_end   (run_end),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

// File: hw/rtl/b64t_front.sv
// ----------------------------------------------------------------------------
// b64t_front
// accepts characters, keeps the bit accumulator and token counters
// ----------------------------------------------------------------------------
module b64t_front #(
  parameter int TOKEN_CHARS = b64t_pkg::TOKEN_CHARS_DEF,
  parameter int TOKEN_BYTES = b64t_pkg::TOKEN_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    character,
  input  logic          final_char,
  input  logic          push,
  output logic          full,
  input  logic          q_full,
  output logic          rec_valid,
  output b64t_pkg::rec_t rec
);
  import b64t_pkg::*;

  localparam int CW = $clog2(TOKEN_CHARS + 2);
  localparam int BW = $clog2(TOKEN_BYTES + 2);

  logic [5:0]    leftover_bits, leftover_bits_next;
  logic [2:0]    leftover_count, leftover_count_next;
  logic [CW-1:0] char_count, char_count_next;
  logic [BW-1:0] bytes_out, bytes_out_next;
  logic          bad_char_seen, bad_now;

  logic          accept;
  logic [6:0]    mapped;
  logic [11:0]   acc;
  logic          byte_ready;
  logic [7:0]    byte_val;
  logic          emit;
  logic [BW+4:0] index_ext;
  status_t       st;

  assign full   = q_full;
  assign accept = push && !q_full;

  always_comb begin
    mapped  = map_char(character);
    bad_now = bad_char_seen || !mapped[6];
    acc     = {leftover_bits, (mapped[6] ? mapped[5:0] : 6'd0)};

    char_count_next = (char_count <= CW'(TOKEN_CHARS)) ? CW'(char_count + 1'b1)
                                                      : char_count;
    // take a byte off the top once eight bits are there
    case (leftover_count)
      3'd2: begin
        byte_ready          = 1'b1;
        byte_val            = acc[7:0];
        leftover_bits_next  = 6'd0;
        leftover_count_next = 3'd0;
      end
      3'd4: begin
        byte_ready          = 1'b1;
        byte_val            = acc[9:2];
        leftover_bits_next  = {4'd0, acc[1:0]};
        leftover_count_next = 3'd2;
      end
      3'd6: begin
        byte_ready          = 1'b1;
        byte_val            = acc[11:4];
        leftover_bits_next  = {2'd0, acc[3:0]};
        leftover_count_next = 3'd4;
      end
      default: begin
        byte_ready          = 1'b0;
        byte_val            = 8'd0;
        leftover_bits_next  = acc[5:0];
        leftover_count_next = 3'd6;
      end
    endcase

    emit = byte_ready && (bytes_out < BW'(TOKEN_BYTES)) && !bad_now;
    bytes_out_next = (byte_ready && (bytes_out <= BW'(TOKEN_BYTES))) ?
                     BW'(bytes_out + 1'b1) : bytes_out;

    if ((char_count_next != CW'(TOKEN_CHARS)) || (bytes_out_next != BW'(TOKEN_BYTES))) begin
      st = STATUS_BAD_LEN;
    end else if (bad_now) begin
      st = STATUS_BAD_CHAR;
    end else if (leftover_bits_next != 6'd0) begin
      st = STATUS_LEFTOVER;
    end else begin
      st = STATUS_OK;
    end

    index_ext      = {5'd0, bytes_out};
    rec.has_byte   = emit;
    rec.byte_val   = byte_val;
    rec.index      = index_ext[4:0];
    rec.has_status = final_char;
    rec.status     = st;
    rec_valid      = accept && (emit || final_char);
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && final_char)) begin
      leftover_bits  <= 6'd0;
      leftover_count <= 3'd0;
      char_count     <= '0;
      bytes_out      <= '0;
      bad_char_seen  <= 1'b0;
    end else if (accept) begin
      leftover_bits  <= leftover_bits_next;
      leftover_count <= leftover_count_next;
      char_count     <= char_count_next;
      bytes_out      <= bytes_out_next;
      bad_char_seen  <= bad_now;
    end
  end

endmodule

// File: hw/rtl/b64t_queue.sv
// ----------------------------------------------------------------------------
// b64t_queue
// short queue of result records between front and back
// ----------------------------------------------------------------------------
`include "base64url_token_decoder_top_defines.svh"

module b64t_queue #(
  parameter int DEPTH = b64t_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  b64t_pkg::rec_t wr_rec,
  output logic           full,
  input  logic           rd_en,
  output b64t_pkg::rec_t rd_rec,
  output logic           empty
);
  import b64t_pkg::*;

  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rec_t             slots [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign rd_rec = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr + 1'b1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr + 1'b1);
      end
      if (wr_en && !rd_en) begin
        count <= CNT_W'(count + 1'b1);
      end else if (rd_en && !wr_en) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

  `B64T_NEVER(a_no_write_when_full, wr_en && full, "queue written while full")
  `B64T_NEVER(a_no_read_when_empty, rd_en && empty, "queue read while empty")

endmodule

// File: hw/rtl/b64t_back.sv
// ----------------------------------------------------------------------------
// b64t_back
// expands queued records into result items behind an output register
// ----------------------------------------------------------------------------
`include "base64url_token_decoder_top_defines.svh"

module b64t_back (
  input  logic           clk,
  input  logic           rst,
  input  b64t_pkg::rec_t head,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           kind,
  output logic [7:0]     data_byte,
  output logic [4:0]     byte_index,
  output logic [1:0]     status,
  output logic           run_end,
  output logic           empty,
  input  logic           pop
);
  import b64t_pkg::*;

  logic out_valid;
  logic phase;      // byte of the head record already sent, status still due
  logic load;
  logic send_byte;

  assign empty     = !out_valid;
  assign load      = !out_valid || pop;
  assign send_byte = head.has_byte && !phase;
  assign q_pop     = load && !q_empty && !(send_byte && head.has_status);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (load) begin
      out_valid <= !q_empty;
      if (!q_empty) begin
        phase <= send_byte && head.has_status;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      if (send_byte) begin
        kind       <= KIND_DATA;
        data_byte  <= head.byte_val;
        byte_index <= head.index;
        status     <= STATUS_OK;
        run_end    <= !head.has_status;
      end else begin
        kind       <= KIND_STATUS;
        data_byte  <= 8'd0;
        byte_index <= 5'd0;
        status     <= head.status;
        run_end    <= 1'b1;
      end
    end
  end

  `B64T_ASSERT(a_phase_has_both,
    phase |-> (!q_empty && head.has_byte && head.has_status), "split record lost")
  `B64T_ASSERT(a_status_after_byte,
    (load && phase) |=> (kind == KIND_STATUS && run_end), "status not sent after byte")
  `B64T_ASSERT(a_hold_until_pop,
    (out_valid && !pop) |=> (out_valid && $stable(kind)), "result dropped before pop")

endmodule
